/* hdl/tsrd_pkg.sv */
// Shared constants and types for the threshold stripe run detector.
package tsrd_pkg;

  // Line geometry
  localparam int MaxStripes   = 32;
  localparam int MaxLineWidth = 4096;
  localparam int ColW         = (MaxLineWidth > 1) ? $clog2(MaxLineWidth) : 1;
  localparam int StripeCntW   = $clog2(MaxStripes + 1);

  // Field widths fixed by the interface
  localparam int PixW    = 8;
  localparam int PosW    = 12;
  localparam int LenW    = 13;
  localparam int NumW    = 5;
  localparam int AccW    = 32;

  localparam logic [LenW-1:0] LenMax         = {LenW{1'b1}};
  localparam logic [PixW-1:0] EmptyThreshold = PixW'((1 << PixW) / 2 - 1);

  // Result kind codes
  localparam logic KindStripe    = 1'b0;
  localparam logic KindThreshold = 1'b1;

  // One stripe record as the tracker reports it
  typedef struct packed {
    logic [PosW-1:0] start_col;
    logic [PosW-1:0] end_col;
    logic [LenW-1:0] length;
    logic            level;
    logic [NumW-1:0] number;
    logic            final_line;
  } stripe_rec_t;

  // What a pixel step produces
  typedef struct packed {
    logic        close_valid;
    stripe_rec_t close_rec;
    logic        final_valid;
    stripe_rec_t final_rec;
  } stripe_step_t;

  // One result request on the output channel
  typedef struct packed {
    logic            result_kind;
    logic [PosW-1:0] stripe_start;
    logic [PosW-1:0] stripe_end;
    logic [LenW-1:0] stripe_length;
    logic            stripe_level;
    logic [NumW-1:0] stripe_number;
    logic            final_of_line;
    logic [PixW-1:0] new_threshold;
    logic            last_result;
  } result_t;

  // Low bits of a column as carried in a position field
  function automatic logic [PosW-1:0] col_field(logic [ColW-1:0] c);
    logic [ColW+PosW-1:0] w;
    w = {{PosW{1'b0}}, c};
    return w[PosW-1:0];
  endfunction

  // Low bits of a stripe position (count minus one)
  function automatic logic [NumW-1:0] num_field(logic [StripeCntW-1:0] s);
    logic [StripeCntW-1:0]      m;
    logic [StripeCntW+NumW-1:0] w;
    m = s - StripeCntW'(1);
    w = {{NumW{1'b0}}, m};
    return w[NumW-1:0];
  endfunction

endpackage

/* hdl/threshold_stripe_run_detector_core.sv */
// Top level of the threshold stripe run detector: sequencer, accumulators, output stage.
//
// Input channel (in_valid_i/in_ready_o) takes one request per item: a pixel
// (kind_i = 0, with last_in_line_i on the final pixel of a line) or an end of
// frame (kind_i = 1). Output channel (out_valid_o/out_ready_i) carries stripe
// records and threshold results, last_result_o set on the final result of an item.
// Pixels are classed against the current threshold (0 after reset).
// A pixel that causes no record is taken without holding the input; one causing
// records holds the input while they move into the output register.
// An end of frame runs the bit-serial divider of the pixel sum by the pixel count,
// one quotient bit per cycle. A queued result moves into the output register once free.
// in_ready_o is high only while the sequencer is idle; it does not wait for
// the output register, so a pixel may be taken while a result waits. When the
// receiver stalls, queued records wait and the input closes at the next record.
// Reset clears the threshold, sum, count and the line state; no output is valid.
module threshold_stripe_run_detector_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [tsrd_pkg::PixW-1:0]     pixel_i,
  input  logic                          last_in_line_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          result_kind_o,
  output logic [tsrd_pkg::PosW-1:0]     stripe_start_o,
  output logic [tsrd_pkg::PosW-1:0]     stripe_end_o,
  output logic [tsrd_pkg::LenW-1:0]     stripe_length_o,
  output logic                          stripe_level_o,
  output logic [tsrd_pkg::NumW-1:0]     stripe_number_o,
  output logic                          final_of_line_o,
  output logic [tsrd_pkg::PixW-1:0]     new_threshold_o,
  output logic                          last_result_o
);
  import tsrd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  function automatic result_t stripe_result(stripe_rec_t r, logic last);
    result_t o;
    o.result_kind   = KindStripe;
    o.stripe_start  = r.start_col;
    o.stripe_end    = r.end_col;
    o.stripe_length = r.length;
    o.stripe_level  = r.level;
    o.stripe_number = r.number;
    o.final_of_line = r.final_line;
    o.new_threshold = '0;
    o.last_result   = last;
    return o;
  endfunction

  state_e          state_q;
  logic [PixW-1:0] threshold_q;
  logic [AccW-1:0] sum_q;
  logic [AccW-1:0] count_q;
  logic            count_zero_q;
  result_t         pend0_q, pend1_q;
  logic [1:0]      pend_cnt_q;
  result_t         out_q;
  logic            out_valid_q;

  logic            accept;
  logic            pix_step;
  logic            eof_step;
  logic            out_free;
  logic            emit;
  stripe_step_t    stripe_step;
  logic            div_done;
  logic [AccW-1:0] quotient;
  logic [PixW-1:0] thr_new;
  result_t         thr_result;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign pix_step   = accept & (kind_i == KindStripe);
  assign eof_step   = accept & (kind_i == KindThreshold);
  assign out_free   = ~out_valid_q | out_ready_i;
  assign emit       = (state_q == ST_EMIT) & out_free & (pend_cnt_q != 2'd0);

  tsrd_stripe u_stripe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (pix_step),
    .pixel_i     (pixel_i),
    .last_i      (last_in_line_i),
    .threshold_i (threshold_q),
    .step_o      (stripe_step)
  );

  tsrd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (eof_step),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Saturated quotient, empty frame gives the midpoint
  always_comb begin
    if (count_zero_q) begin
      thr_new = EmptyThreshold;
    end else if (quotient[AccW-1:PixW] != '0) begin
      thr_new = {PixW{1'b1}};
    end else begin
      thr_new = quotient[PixW-1:0];
    end
    thr_result               = '0;
    thr_result.result_kind   = KindThreshold;
    thr_result.new_threshold = thr_new;
    thr_result.last_result   = 1'b1;
  end

  // Sequencer, accumulators and threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      threshold_q  <= '0;
      sum_q        <= '0;
      count_q      <= '0;
      count_zero_q <= 1'b0;
      pend_cnt_q   <= 2'd0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (pix_step) begin
            sum_q      <= sum_q + AccW'(pixel_i);
            count_q    <= count_q + AccW'(1);
            pend_cnt_q <= 2'(stripe_step.close_valid) + 2'(stripe_step.final_valid);
            if (stripe_step.close_valid | stripe_step.final_valid) begin
              state_q <= ST_EMIT;
            end
          end else if (eof_step) begin
            count_zero_q <= (count_q == '0);
            sum_q        <= '0;
            count_q      <= '0;
            state_q      <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            threshold_q <= thr_new;
            pend_cnt_q  <= 2'd1;
            state_q     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            pend_cnt_q <= pend_cnt_q - 2'd1;
            if (pend_cnt_q == 2'd1) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Pending result records
  always_ff @(posedge clk_i) begin
    if (pix_step) begin
      if (stripe_step.close_valid) begin
        pend0_q <= stripe_result(stripe_step.close_rec, ~stripe_step.final_valid);
        pend1_q <= stripe_result(stripe_step.final_rec, 1'b1);
      end else begin
        pend0_q <= stripe_result(stripe_step.final_rec, 1'b1);
      end
    end else if ((state_q == ST_DIV) && div_done) begin
      pend0_q <= thr_result;
    end else if (emit) begin
      pend0_q <= pend1_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= pend0_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_q.result_kind;
  assign stripe_start_o  = out_q.stripe_start;
  assign stripe_end_o    = out_q.stripe_end;
  assign stripe_length_o = out_q.stripe_length;
  assign stripe_level_o  = out_q.stripe_level;
  assign stripe_number_o = out_q.stripe_number;
  assign final_of_line_o = out_q.final_of_line;
  assign new_threshold_o = out_q.new_threshold;
  assign last_result_o   = out_q.last_result;

endmodule

/* hdl/tsrd_div.sv */
// Iterative restoring divider, one quotient bit per cycle over a shared subtractor.
module tsrd_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tsrd_pkg::AccW-1:0] dividend_i,
  input  logic [tsrd_pkg::AccW-1:0] divisor_i,
  output logic                     done_o,
  output logic [tsrd_pkg::AccW-1:0] quotient_o
);
  import tsrd_pkg::*;

  localparam int StepW = $clog2(AccW);

  logic               busy_q;
  logic [StepW-1:0]   step_q;
  logic [AccW-1:0]    rem_q;
  logic [AccW-1:0]    quo_q;
  logic [AccW-1:0]    dsr_q;
  logic               done_q;
  logic [AccW:0]      trial;
  logic               fits;

  // Shared subtract: partial remainder with next dividend bit against divisor
  assign trial = {rem_q, quo_q[AccW-1]} - {1'b0, dsr_q};
  assign fits  = ~trial[AccW];

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(AccW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out of quo_q as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[AccW-1:0] : {rem_q[AccW-2:0], quo_q[AccW-1]};
      quo_q <= {quo_q[AccW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/tsrd_stripe.sv */
// Stripe tracker: classifies pixels and opens, extends and closes stripes of a line.
module tsrd_stripe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [tsrd_pkg::PixW-1:0]     pixel_i,
  input  logic                          last_i,
  input  logic [tsrd_pkg::PixW-1:0]     threshold_i,
  output tsrd_pkg::stripe_step_t        step_o
);
  import tsrd_pkg::*;

  logic [ColW-1:0]       column_q;
  logic [ColW-1:0]       open_start_q, open_start_d;
  logic [ColW-1:0]       open_end_q, open_end_d;
  logic [LenW-1:0]       open_len_q, open_len_d;
  logic                  open_level_q, open_level_d;
  logic [StripeCntW-1:0] stripes_q, stripes_d;
  logic [ColW-1:0]       column_inc;
  logic                  level;
  logic                  close_valid;

  assign level      = (pixel_i >= threshold_i);
  assign column_inc = (column_q < ColW'(MaxLineWidth - 1)) ? column_q + ColW'(1) : column_q;

  // Next open stripe
  always_comb begin
    open_start_d = open_start_q;
    open_end_d   = open_end_q;
    open_len_d   = open_len_q;
    open_level_d = open_level_q;
    stripes_d    = stripes_q;
    close_valid  = 1'b0;
    if (stripes_q == '0) begin
      open_start_d = column_q;
      open_end_d   = column_q;
      open_len_d   = LenW'(1);
      open_level_d = level;
      stripes_d    = StripeCntW'(1);
    end else if (level == open_level_q) begin
      open_end_d = column_q;
      if (open_len_q != LenMax) begin
        open_len_d = open_len_q + LenW'(1);
      end
    end else if (stripes_q < StripeCntW'(MaxStripes)) begin
      close_valid  = 1'b1;
      open_start_d = column_q;
      open_end_d   = column_q;
      open_len_d   = LenW'(1);
      open_level_d = level;
      stripes_d    = stripes_q + StripeCntW'(1);
    end
  end

  // Records: closing stripe from current state, final one from next state
  always_comb begin
    step_o.close_valid          = close_valid;
    step_o.close_rec.start_col  = col_field(open_start_q);
    step_o.close_rec.end_col    = col_field(open_end_q);
    step_o.close_rec.length     = open_len_q;
    step_o.close_rec.level      = open_level_q;
    step_o.close_rec.number     = num_field(stripes_q);
    step_o.close_rec.final_line = 1'b0;
    step_o.final_valid          = last_i;
    step_o.final_rec.start_col  = col_field(open_start_d);
    step_o.final_rec.end_col    = col_field(open_end_d);
    step_o.final_rec.length     = open_len_d;
    step_o.final_rec.level      = open_level_d;
    step_o.final_rec.number     = num_field(stripes_d);
    step_o.final_rec.final_line = 1'b1;
  end

  // State update on each accepted pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q     <= '0;
      open_start_q <= '0;
      open_end_q   <= '0;
      open_len_q   <= '0;
      open_level_q <= 1'b0;
      stripes_q    <= '0;
    end else if (step_i) begin
      open_start_q <= open_start_d;
      open_end_q   <= open_end_d;
      open_len_q   <= open_len_d;
      open_level_q <= open_level_d;
      stripes_q    <= last_i ? '0 : stripes_d;
      column_q     <= last_i ? '0 : column_inc;
    end
  end

endmodule
